>>> rtl/mfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants and types of the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int TASKS   = 1024;
	localparam int LEVELS  = 3;
	localparam int ID_W    = $clog2(TASKS);
	localparam int CNT_W   = $clog2(TASKS + 1);
	localparam int FIFO_AW = $clog2(LEVELS * TASKS);

	localparam int TID_W   = 10;
	localparam int TIME_W  = 32;
	localparam int WORK_W  = 24;
	localparam int QNT_W   = 16;
	localparam int LVL_W   = 2;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 136;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = QNT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TOP    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_MIDDLE = 1'b1;

	localparam logic [QNT_W-1:0] QUANTUM_TOP_RST    = 16'd8;
	localparam logic [QNT_W-1:0] QUANTUM_MIDDLE_RST = 16'd16;

	localparam logic ACT_ARRIVE   = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	typedef logic [LVL_W-1:0] lvl_t;

	localparam lvl_t LVL_TOP    = 2'd0;
	localparam lvl_t LVL_MIDDLE = 2'd1;
	localparam lvl_t LVL_BOTTOM = 2'd2;

	typedef struct packed {
		logic [WORK_W-1:0] work;
		logic [TIME_W-1:0] arrived;
		logic              seen;
		logic              active;
	} task_t;

endpackage
`default_nettype wire

>>> rtl/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Three-level feedback queue scheduler. Task records and the three level
// queues live in two synchronous memories; queue pointers and the time
// counter are in flops.
// ----------------------------------------------------------------------------
// An arrival reads the task memory, then writes the record and the level 0
// queue. A dispatch reads the head from the queue memory, then reads the task
// memory, then updates and writes back; the update step waits while the result
// register is still full. A dispatch with all queues empty gives an idle
// result once the result register is free. After reset the task memory is
// swept to mark all tasks inactive, one entry per cycle, during which no item
// is accepted; configuration writes are taken at any time.
module multilevel_feedback_scheduler (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [mfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [mfs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// task_id[9:0], arr_time[41:10], burst_length[65:42], zero pad
	input  wire  [mfs_pkg::IN_TDATA_W-1:0]     s_tdata,
	// action[0]
	input  wire                                s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// served_task[9:0], served_level[11:10], start_time[43:12],
	// slice_length[67:44], end_time[99:68], finished[100],
	// first_dispatch[101], response_time[133:102], zero pad
	output logic [mfs_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// idle[0]
	output logic                               m_tuser
);
	import mfs_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ARR,
		ST_FIFO,
		ST_TASK,
		ST_EMPTY
	} state_t;

	function automatic logic [ID_W-1:0] ptr_inc(input logic [ID_W-1:0] p);
		return (p == ID_W'(TASKS - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [FIFO_AW-1:0] fifo_addr(input lvl_t l, input logic [ID_W-1:0] p);
		return FIFO_AW'(l) * FIFO_AW'(TASKS) + FIFO_AW'(p);
	endfunction

	state_t                  state_q;
	logic [ID_W-1:0]         clr_cnt_q;
	logic [TIME_W-1:0]       clock_q;
	logic [QNT_W-1:0]        qtop_q;
	logic [QNT_W-1:0]        qmid_q;
	logic [ID_W-1:0]         head_q [LEVELS];
	logic [ID_W-1:0]         tail_q [LEVELS];
	logic [CNT_W-1:0]        cnt_q  [LEVELS];
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic                    m_tuser_q;

	logic [TID_W-1:0]        tid_q;
	logic [TIME_W-1:0]       arr_q;
	logic [WORK_W-1:0]       burst_q;
	lvl_t                    lvl_q;

	task_t                   task_mem [TASKS];
	task_t                   tm_rd_q;
	logic                    tm_re, tm_we;
	logic [ID_W-1:0]         tm_raddr, tm_waddr;
	task_t                   tm_wdata;

	logic [ID_W-1:0]         fifo_mem [LEVELS * TASKS];
	logic [ID_W-1:0]         fm_rd_q;
	logic                    fm_re, fm_we;
	logic [FIFO_AW-1:0]      fm_raddr, fm_waddr;
	logic [ID_W-1:0]         fm_wdata;

	logic                    accept, out_free, out_load, all_empty, arr_ok, push0_ok;
	lvl_t                    sel_lvl, nxt_lvl;
	logic [WORK_W-1:0]       quantum, slice, rem_next;
	logic [TIME_W-1:0]       end_time, resp;
	logic                    finished;
	logic [OUT_TDATA_W-1:0]  out_word;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = ((state_q == ST_TASK) || (state_q == ST_EMPTY)) && out_free;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign all_empty = (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0);
	assign arr_ok    = (32'(tid_q) < TASKS) && !tm_rd_q.active;
	assign push0_ok  = (cnt_q[0] != CNT_W'(TASKS));

	always_comb begin
		priority if (cnt_q[0] != '0) sel_lvl = LVL_TOP;
		else if (cnt_q[1] != '0)     sel_lvl = LVL_MIDDLE;
		else                         sel_lvl = LVL_BOTTOM;
	end

	always_comb begin
		unique case (lvl_q)
			LVL_TOP:    quantum = WORK_W'(qtop_q);
			LVL_MIDDLE: quantum = WORK_W'(qmid_q);
			default:    quantum = tm_rd_q.work;
		endcase
		slice    = (quantum < tm_rd_q.work) ? quantum : tm_rd_q.work;
		rem_next = tm_rd_q.work - slice;
		finished = (rem_next == '0);
		end_time = clock_q + TIME_W'(slice);
		resp     = tm_rd_q.seen ? '0 : clock_q - tm_rd_q.arrived;
		nxt_lvl  = (lvl_q == LVL_BOTTOM) ? LVL_BOTTOM : lvl_q + 1'b1;
		out_word = {2'b00, resp, !tm_rd_q.seen, finished, end_time, slice, clock_q,
			lvl_q, TID_W'(fm_rd_q)};
	end

	always_comb begin
		tm_re    = 1'b0;
		tm_raddr = '0;
		tm_we    = 1'b0;
		tm_waddr = '0;
		tm_wdata = '0;
		fm_re    = 1'b0;
		fm_raddr = '0;
		fm_we    = 1'b0;
		fm_waddr = '0;
		fm_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				tm_we    = 1'b1;
				tm_waddr = clr_cnt_q;
			end
			ST_IDLE: begin
				if (accept && s_tuser == ACT_ARRIVE) begin
					tm_re    = 1'b1;
					tm_raddr = ID_W'(s_tdata[TID_W-1:0]);
				end else if (accept && !all_empty) begin
					fm_re    = 1'b1;
					fm_raddr = fifo_addr(sel_lvl, head_q[sel_lvl]);
				end
			end
			ST_ARR: begin
				if (arr_ok) begin
					tm_we    = 1'b1;
					tm_waddr = ID_W'(tid_q);
					tm_wdata = '{work: burst_q, arrived: arr_q, seen: 1'b0, active: 1'b1};
					fm_we    = push0_ok;
					fm_waddr = fifo_addr(LVL_TOP, tail_q[0]);
					fm_wdata = ID_W'(tid_q);
				end
			end
			ST_FIFO: begin
				tm_re    = 1'b1;
				tm_raddr = fm_rd_q;
			end
			ST_TASK: begin
				if (out_free) begin
					tm_we    = 1'b1;
					tm_waddr = fm_rd_q;
					tm_wdata = '{work: rem_next, arrived: tm_rd_q.arrived, seen: 1'b1,
						active: !finished};
					fm_we    = !finished;
					fm_waddr = fifo_addr(nxt_lvl, tail_q[nxt_lvl]);
					fm_wdata = fm_rd_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tm_we) task_mem[tm_waddr] <= tm_wdata;
		if (tm_re) tm_rd_q <= task_mem[tm_raddr];
	end

	always_ff @(posedge clk) begin
		if (fm_we) fifo_mem[fm_waddr] <= fm_wdata;
		if (fm_re) fm_rd_q <= fifo_mem[fm_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tid_q   <= s_tdata[TID_W-1:0];
			arr_q   <= s_tdata[TID_W +: TIME_W];
			burst_q <= s_tdata[TID_W + TIME_W +: WORK_W];
			lvl_q   <= sel_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			clock_q    <= '0;
			qtop_q     <= QUANTUM_TOP_RST;
			qmid_q     <= QUANTUM_MIDDLE_RST;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_QUANTUM_TOP:    qtop_q <= cfg_data;
					CFG_QUANTUM_MIDDLE: qmid_q <= cfg_data;
				endcase
			end
			if (m_tvalid_q && m_tready && !out_load) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= ptr_inc(clr_cnt_q);
					if (clr_cnt_q == ID_W'(TASKS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == ACT_ARRIVE) begin
							state_q <= ST_ARR;
						end else if (all_empty) begin
							state_q <= ST_EMPTY;
						end else begin
							head_q[sel_lvl] <= ptr_inc(head_q[sel_lvl]);
							cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - 1'b1;
							state_q         <= ST_FIFO;
						end
					end
				end
				ST_ARR: begin
					if (arr_ok) begin
						if (all_empty && arr_q > clock_q) clock_q <= arr_q;
						if (push0_ok) begin
							tail_q[0] <= ptr_inc(tail_q[0]);
							cnt_q[0]  <= cnt_q[0] + 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_FIFO: begin
					state_q <= ST_TASK;
				end
				ST_TASK: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= out_word;
						m_tuser_q  <= 1'b0;
						clock_q    <= end_time;
						if (!finished) begin
							tail_q[nxt_lvl] <= ptr_inc(tail_q[nxt_lvl]);
							cnt_q[nxt_lvl]  <= cnt_q[nxt_lvl] + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= '0;
						m_tuser_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/mfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks of the scheduler result stream.
// ----------------------------------------------------------------------------
module mfs_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [mfs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input wire                              m_tuser
);
	import mfs_pkg::*;

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("idle result with nonzero fields");

	a_end_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[99:68] == m_tdata[43:12] + {8'h00, m_tdata[67:44]})
		else $error("end time is not start plus slice");

	a_resp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && !m_tdata[101] |-> m_tdata[133:102] == '0)
		else $error("response time set on a later dispatch");

	a_bottom_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && m_tdata[11:10] == LVL_BOTTOM |-> m_tdata[100])
		else $error("bottom level slice left work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (.*);
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-level feedback queue scheduler. A queue
// of arrive and dispatch items feeds a stream driver; an in-bench scheduler
// model predicts every dispatch result, and a monitor compares each result
// transfer field by field. Quanta change between phases, with random idling
// on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
	import mfs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic               action;
		logic [TID_W-1:0]   tid;
		logic [TIME_W-1:0]  arr;
		logic [WORK_W-1:0]  burst;
		bit                 sync;
	} sched_item_t;

	typedef struct packed {
		logic [TID_W-1:0]   served_id;
		lvl_t               level;
		logic [TIME_W-1:0]  start_t;
		logic [WORK_W-1:0]  slice_len;
		logic [TIME_W-1:0]  end_t;
		logic               finished;
		logic               first_disp;
		logic [TIME_W-1:0]  resp_t;
		logic               idle;
	} dispatch_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	multilevel_feedback_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// scheduler model state
	logic [QNT_W-1:0]  qtop_cfg = QUANTUM_TOP_RST;
	logic [QNT_W-1:0]  qmid_cfg = QUANTUM_MIDDLE_RST;
	logic [TIME_W-1:0] sched_clock = '0;
	logic [WORK_W-1:0] work_mem [TASKS];
	logic [TIME_W-1:0] arrived_mem [TASKS];
	bit                seen_mem [TASKS];
	bit                active_mem [TASKS] = '{default: 1'b0};
	logic [TID_W-1:0]  level_q [LEVELS][$];

	sched_item_t job_q [$];
	dispatch_t   due_dispatches [$];
	sched_item_t presented;
	int          src_idle_pct = 37;
	int          snk_idle_pct = 48;
	int          mismatch_count = 0;
	int          result_count = 0;
	int          cycle_count = 0;
	logic [TIME_W-1:0] next_arr = '0;

	task automatic predict_step(input sched_item_t it);
		dispatch_t         r;
		lvl_t              lv;
		logic [TID_W-1:0]  id;
		logic [WORK_W-1:0] rem;
		logic [WORK_W-1:0] quant;
		logic [WORK_W-1:0] slice;
		if (it.action == ACT_ARRIVE) begin
			if (active_mem[it.tid])
				return;
			if (level_q[0].size() == 0 && level_q[1].size() == 0 &&
					level_q[2].size() == 0 && it.arr > sched_clock)
				sched_clock = it.arr;
			work_mem[it.tid] = it.burst;
			arrived_mem[it.tid] = it.arr;
			seen_mem[it.tid] = 1'b0;
			active_mem[it.tid] = 1'b1;
			level_q[LVL_TOP].push_back(it.tid);
			return;
		end
		r = '0;
		if (level_q[LVL_TOP].size() != 0)
			lv = LVL_TOP;
		else if (level_q[LVL_MIDDLE].size() != 0)
			lv = LVL_MIDDLE;
		else if (level_q[LVL_BOTTOM].size() != 0)
			lv = LVL_BOTTOM;
		else begin
			r.idle = 1'b1;
			due_dispatches.push_back(r);
			return;
		end
		id = level_q[lv].pop_front();
		rem = work_mem[id];
		if (lv == LVL_TOP)
			quant = WORK_W'(qtop_cfg);
		else if (lv == LVL_MIDDLE)
			quant = WORK_W'(qmid_cfg);
		else
			quant = rem;
		slice = (quant < rem) ? quant : rem;
		r.served_id = id;
		r.level = lv;
		r.start_t = sched_clock;
		r.slice_len = slice;
		if (!seen_mem[id]) begin
			seen_mem[id] = 1'b1;
			r.first_disp = 1'b1;
			r.resp_t = sched_clock - arrived_mem[id];
		end
		sched_clock = sched_clock + TIME_W'(slice);
		rem = rem - slice;
		work_mem[id] = rem;
		r.end_t = sched_clock;
		if (rem == '0) begin
			r.finished = 1'b1;
			active_mem[id] = 1'b0;
		end else
			level_q[(lv == LVL_BOTTOM) ? LVL_BOTTOM : lv + 1'b1].push_back(id);
		due_dispatches.push_back(r);
	endtask

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_step(presented);
			if (!s_tvalid || s_tready) begin
				if (job_q.size() != 0 && !(job_q[0].sync && due_dispatches.size() != 0) &&
						$urandom_range(99) >= src_idle_pct) begin
					presented = job_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, presented.burst, presented.arr, presented.tid};
					s_tuser <= presented.action;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR result %0d: %s", result_count, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		dispatch_t got;
		dispatch_t want;
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			if (m_tvalid && m_tready) begin
				got.served_id  = m_tdata[9:0];
				got.level      = m_tdata[11:10];
				got.start_t    = m_tdata[43:12];
				got.slice_len  = m_tdata[67:44];
				got.end_t      = m_tdata[99:68];
				got.finished   = m_tdata[100];
				got.first_disp = m_tdata[101];
				got.resp_t     = m_tdata[133:102];
				got.idle       = m_tuser;
				if (due_dispatches.size() == 0)
					report_mismatch("result transfer with nothing expected");
				else begin
					want = due_dispatches.pop_front();
					check_field("served_task", 32'(got.served_id), 32'(want.served_id));
					check_field("served_level", 32'(got.level), 32'(want.level));
					check_field("start_time", got.start_t, want.start_t);
					check_field("slice_length", 32'(got.slice_len), 32'(want.slice_len));
					check_field("end_time", got.end_t, want.end_t);
					check_field("finished", 32'(got.finished), 32'(want.finished));
					check_field("first_dispatch", 32'(got.first_disp), 32'(want.first_disp));
					check_field("response_time", got.resp_t, want.resp_t);
					check_field("idle", 32'(got.idle), 32'(want.idle));
				end
				result_count++;
			end
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic arrive(input logic [TID_W-1:0] tid, input logic [TIME_W-1:0] arr,
			input logic [WORK_W-1:0] burst, input bit sync = 1'b0);
		sched_item_t it;
		it.action = ACT_ARRIVE;
		it.tid = tid;
		it.arr = arr;
		it.burst = burst;
		it.sync = sync;
		job_q.push_back(it);
	endtask

	task automatic dispatch(input bit sync = 1'b0);
		sched_item_t it;
		it.action = ACT_DISPATCH;
		it.tid = TID_W'($urandom);
		it.arr = $urandom;
		it.burst = WORK_W'($urandom);
		it.sync = sync;
		job_q.push_back(it);
	endtask

	task automatic wait_quiet();
		while (job_q.size() != 0 || s_tvalid || due_dispatches.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_quanta(input logic [QNT_W-1:0] qt, input logic [QNT_W-1:0] qm);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_QUANTUM_TOP;
		cfg_data <= qt;
		@(posedge clk);
		cfg_index <= CFG_QUANTUM_MIDDLE;
		cfg_data <= qm;
		@(posedge clk);
		cfg_we <= 1'b0;
		qtop_cfg = qt;
		qmid_cfg = qm;
	endtask

	// mostly well-formed traffic: steady arrivals mixed with dispatches
	task automatic add_random(input int n);
		int          sel;
		logic [TID_W-1:0]  tid;
		logic [WORK_W-1:0] burst;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 52) begin
				tid = ($urandom_range(3) == 0) ? TID_W'($urandom_range(15)) : TID_W'($urandom);
				if ($urandom_range(29) == 0)
					next_arr = $urandom;
				else
					next_arr = next_arr + $urandom_range(40);
				sel = $urandom_range(99);
				if (sel < 3)
					burst = '0;
				else if (sel < 6)
					burst = '1;
				else if (sel < 10)
					burst = WORK_W'($urandom);
				else
					burst = WORK_W'($urandom_range(60, 1));
				arrive(tid, next_arr, burst, $urandom_range(299) == 0);
			end else
				dispatch($urandom_range(299) == 0);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset quanta: empty dispatch, clock jump, zero burst, repeated id,
		// future arrival, demotion through all levels
		dispatch();
		arrive(10'd0, 32'd100, 24'd20);
		arrive(10'd1023, 32'd0, 24'd0);
		arrive(10'd0, 32'd150, 24'd5);
		arrive(10'd5, 32'd200, 24'hFFFFFF);
		repeat (7) dispatch();
		// clock wrap after a jump near the top of the range
		arrive(10'd512, 32'hFFFF_FFF8, 24'd30, 1'b1);
		repeat (3) dispatch();
		wait_quiet();

		// zero quanta still demote
		write_quanta('0, '0);
		arrive(10'd682, 32'd0, 24'd3);
		arrive(10'd341, 32'd4, 24'd1);
		repeat (4) dispatch();
		wait_quiet();

		write_quanta(16'd3, 16'd7);
		add_random(200);
		wait_quiet();
		write_quanta(16'hFFFF, 16'hFFFF);
		add_random(200);
		wait_quiet();

		src_idle_pct = 48;
		snk_idle_pct = 37;
		write_quanta(16'd1, 16'd1);
		add_random(200);
		wait_quiet();
		write_quanta(16'd0, 16'd5);
		add_random(150);
		wait_quiet();
		write_quanta(16'd2, 16'hFFFF);
		add_random(100);
		wait_quiet();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_quanta(16'd8, 16'd16);
		add_random(350);
		wait_quiet();

		if (mismatch_count == 0 && due_dispatches.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
